>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define L2BH_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("l2bh assertion failed");

// Expression must never be true at a rising clock edge outside reset.
`define L2BH_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("l2bh forbidden condition seen");

`endif

>>> rtl/l2bh_pkg.sv
// Package: types, constants and mix tables of the lookup2 byte hash core.
`timescale 1ns / 1ps
package l2bh_pkg;

  localparam logic [31:0] GoldenRatio   = 32'h9e3779b9;
  localparam logic [31:0] InitWordC     = 32'd13;
  localparam int          GroupBytes    = 12;
  localparam int          TailBytes     = GroupBytes - 1;
  localparam int          FillW         = $clog2(GroupBytes);
  localparam int          QueueDepthDef = 2;
  localparam int          MixSteps      = 9;
  localparam int          StepW         = $clog2(MixSteps);
  localparam logic [StepW-1:0] LastMixStep = StepW'(MixSteps - 1);

  // Work handed from the byte collector to the mixer
  typedef struct packed {
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] key_len;
    logic        grp_full;   // words are a complete 12-byte group
    logic        is_last;    // key ends with this job
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    RoleA,
    RoleB,
    RoleC
  } mix_role_e;

  // Word updated by each line of the mix
  function automatic mix_role_e mix_role(input logic [StepW-1:0] step);
    mix_role_e r;
    unique case (step)
      4'd0, 4'd3, 4'd6: r = RoleA;
      4'd1, 4'd4, 4'd7: r = RoleB;
      default:          r = RoleC;
    endcase
    return r;
  endfunction

  // Shift distance of each line of the mix
  function automatic logic [4:0] mix_shift(input logic [StepW-1:0] step);
    logic [4:0] s;
    unique case (step)
      4'd0:    s = 5'd13;
      4'd1:    s = 5'd8;
      4'd2:    s = 5'd13;
      4'd3:    s = 5'd12;
      4'd4:    s = 5'd16;
      4'd5:    s = 5'd5;
      4'd6:    s = 5'd3;
      4'd7:    s = 5'd10;
      default: s = 5'd15;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/l2bh_front.sv
// Front end: collects key bytes into groups and issues mix jobs.
`timescale 1ns / 1ps
module l2bh_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            xfer_i,
  input  logic [7:0]      key_byte_i,
  input  logic            byte_present_i,
  input  logic            last_byte_i,
  output logic            push_o,
  output l2bh_pkg::job_t  job_o
);
  import l2bh_pkg::*;

  logic [7:0]       grp_q [TailBytes];
  logic [7:0]       grp_n [TailBytes];
  logic [FillW-1:0] fill_q, fill_d;
  logic [31:0]      len_q, len_d;
  logic             grp_full;

  // Insert the new byte into the collected group
  always_comb begin
    for (int i = 0; i < TailBytes; i++) begin
      grp_n[i] = (byte_present_i && (fill_q == FillW'(i))) ? key_byte_i : grp_q[i];
    end
  end

  assign grp_full = byte_present_i && (fill_q == FillW'(TailBytes));
  assign len_d    = len_q + {31'd0, byte_present_i};

  // Build the job: full group words, or the tail with word_c shifted up a byte
  always_comb begin
    job_o.word_a   = {grp_n[3], grp_n[2], grp_n[1], grp_n[0]};
    job_o.word_b   = {grp_n[7], grp_n[6], grp_n[5], grp_n[4]};
    job_o.word_c   = grp_full ? {key_byte_i, grp_q[10], grp_q[9], grp_q[8]}
                              : {grp_n[10], grp_n[9], grp_n[8], 8'h00};
    job_o.key_len  = len_d;
    job_o.grp_full = grp_full;
    job_o.is_last  = last_byte_i;
  end

  assign push_o = xfer_i && (grp_full || last_byte_i);

  // Next fill count
  always_comb begin
    fill_d = fill_q;
    if (grp_full || last_byte_i) begin
      fill_d = '0;
    end else if (byte_present_i) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  // Advance collection state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      for (int i = 0; i < TailBytes; i++) begin
        grp_q[i] <= '0;
      end
    end else if (xfer_i) begin
      fill_q <= fill_d;
      len_q  <= last_byte_i ? 32'd0 : len_d;
      for (int i = 0; i < TailBytes; i++) begin
        grp_q[i] <= (grp_full || last_byte_i) ? 8'h00 : grp_n[i];
      end
    end
  end

endmodule

>>> rtl/l2bh_fifo.sv
// Job queue between the byte collector and the mixer.
`timescale 1ns / 1ps
module l2bh_fifo #(
  parameter int Depth = l2bh_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  l2bh_pkg::job_t      push_data_i,
  input  logic                pop_i,
  output l2bh_pkg::job_t      pop_data_o,
  output l2bh_pkg::q_status_t status_o
);
  import l2bh_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/l2bh_back.sv
// Back end: adds jobs into the hash words, runs the mix, holds the result.
`timescale 1ns / 1ps
module l2bh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  l2bh_pkg::job_t      job_i,
  input  l2bh_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic [31:0]         hash_value_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import l2bh_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMix  = 2'd1;
  localparam logic [1:0] StLen  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]       state_q;
  logic [StepW-1:0] step_q;
  logic [31:0]      a_q, b_q, c_q, len_q;
  logic             is_last_q, two_pass_q;
  logic             out_valid_q;
  logic [31:0]      hash_q;
  logic [31:0]      mix_val;
  logic [4:0]       sh;
  mix_role_e        role;
  logic [31:0]      c_extra;
  logic             load_out;

  assign pop_o   = (state_q == StIdle) && !q_status_i.empty;
  assign c_extra = (job_i.is_last && !job_i.grp_full) ? job_i.key_len : 32'd0;
  assign load_out = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  // One line of the mix: two subtracts and a shifted xor
  always_comb begin
    role = mix_role(step_q);
    sh   = mix_shift(step_q);
    unique case (role)
      RoleA:   mix_val = (a_q - b_q - c_q) ^ (c_q >> sh);
      RoleB:   mix_val = (b_q - c_q - a_q) ^ (a_q << sh);
      default: mix_val = (c_q - a_q - b_q) ^ (b_q >> sh);
    endcase
  end

  // Sequence add, mix, length add and result handoff
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      step_q     <= '0;
      a_q        <= GoldenRatio;
      b_q        <= GoldenRatio;
      c_q        <= InitWordC;
      len_q      <= '0;
      is_last_q  <= 1'b0;
      two_pass_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (pop_o) begin
            a_q        <= a_q + job_i.word_a;
            b_q        <= b_q + job_i.word_b;
            c_q        <= c_q + job_i.word_c + c_extra;
            len_q      <= job_i.key_len;
            is_last_q  <= job_i.is_last;
            two_pass_q <= job_i.is_last && job_i.grp_full;
            step_q     <= '0;
            state_q    <= StMix;
          end
        end
        StMix: begin
          unique case (role)
            RoleA:   a_q <= mix_val;
            RoleB:   b_q <= mix_val;
            default: c_q <= mix_val;
          endcase
          if (step_q == LastMixStep) begin
            step_q <= '0;
            if (two_pass_q) begin
              two_pass_q <= 1'b0;
              state_q    <= StLen;
            end else if (is_last_q) begin
              state_q <= StOut;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        StLen: begin
          c_q     <= c_q + len_q;
          state_q <= StMix;
        end
        default: begin
          if (load_out) begin
            a_q     <= GoldenRatio;
            b_q     <= GoldenRatio;
            c_q     <= InitWordC;
            state_q <= StIdle;
          end
        end
      endcase
    end
  end

  // Output register: fill on finish, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      hash_q <= c_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

>>> rtl/lookup2_byte_hash_core.sv
// Top level: streaming lookup2 32-bit byte hash with decoupled collector and mixer.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, key_byte_i,              | sink
//          | byte_present_i, last_byte_i                      |
//  out     | out_valid_o, out_stall_i, hash_value_o           | source
//
// Bytes are taken one per cycle; the collector never waits on the mixer
// until the job queue (QueueDepth entries) is full.
// A full 12-byte group costs the mixer one add and nine mix lines.
// Finishing a key takes the add, the mix and a result handoff, plus a length add
// and a second mix if the last byte ends a group; one mix-line unit sets this.
// Reset (rst_ni low) clears the group, length, queue and words at once.
// out_stall_i holds the result register; in_stall_o rises only on a full queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lookup2_byte_hash_core #(
  parameter int QueueDepth = l2bh_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  key_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);
  import l2bh_pkg::*;

  logic      in_xfer;
  logic      q_push, q_pop;
  job_t      q_job_in, q_job_out;
  q_status_t q_stat;

  assign in_stall_o = q_stat.full;
  assign in_xfer    = in_valid_i && !in_stall_o;

  l2bh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .xfer_i         (in_xfer),
    .key_byte_i     (key_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .push_o         (q_push),
    .job_o          (q_job_in)
  );

  l2bh_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_job_in),
    .pop_i       (q_pop),
    .pop_data_o  (q_job_out),
    .status_o    (q_stat)
  );

  l2bh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (q_job_out),
    .q_status_i   (q_stat),
    .pop_o        (q_pop),
    .hash_value_o (hash_value_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

  // Queue integrity between collector and mixer
  `L2BH_NEVER(a_push_when_full, clk_i, rst_ni, q_push && q_stat.full)
  `L2BH_NEVER(a_pop_when_empty, clk_i, rst_ni, q_pop && q_stat.empty)
  `L2BH_ASSERT(a_push_fills, clk_i, rst_ni, (q_push && !q_pop) |=> !q_stat.empty)
  `L2BH_ASSERT(a_full_stalls, clk_i, rst_ni, q_stat.full |-> !q_push)

endmodule
